// ===== sv/sha256_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 shared definitions
// Beat types, controller states, command/status structs and round constants.
// ----------------------------------------------------------------------------
package sha256_pkg;

	localparam int BlockBytes = 64;
	localparam int Rounds     = 64;
	localparam int CountW     = 61;

	typedef struct packed {
		logic [7:0] message_byte;
		logic       has_byte;
		logic       end_of_message;
	} in_beat_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FOLD,
		ST_PAD,
		ST_EMIT
	} state_t;

	// padding pass selector
	typedef enum logic [1:0] {
		PAD_NONE,
		PAD_FIRST,
		PAD_LEN
	} pad_t;

	typedef struct packed {
		logic       take_byte;
		logic       start_rounds;
		logic       round_step;
		logic       fold;
		logic       pad_first;
		logic       pad_len;
		logic       reload;
	} dp_cmd_t;

	typedef struct packed {
		logic       block_full;
		logic       rounds_done;
		logic       pad_two;
	} dp_sts_t;

	localparam logic [31:0] RoundK [Rounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PadMark = 8'h80;

endpackage

// ===== sv/sha256_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 datapath
// Block buffer of sixteen words, rolling message schedule, one round per
// cycle, chained hash and padding insertion.
// ----------------------------------------------------------------------------
module sha256_datapath import sha256_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  dp_cmd_t         cmd,
	input  logic [7:0]      byte_in,
	output dp_sts_t         sts,
	output logic [31:0]     hash_word [8]
);

	logic [31:0]       w_q [16];
	logic [31:0]       h_q [8];
	logic [31:0]       a_q, b_q, c_q, d_q, e_q, f_q, g_q, hh_q;
	logic [5:0]        fill_q;
	logic [5:0]        round_q;
	logic [CountW-1:0] count_q;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
		rotr = (v >> n) | (v << (32 - n));
	endfunction

	logic [31:0] s0, s1, w_new, big1, big0, ch, maj, t1, t2;
	logic [63:0] bit_len;

	assign s0      = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1      = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign w_new   = w_q[0] + s0 + w_q[9] + s1;
	assign big1    = rotr(e_q, 6) ^ rotr(e_q, 11) ^ rotr(e_q, 25);
	assign ch      = (e_q & f_q) ^ (~e_q & g_q);
	assign big0    = rotr(a_q, 2) ^ rotr(a_q, 13) ^ rotr(a_q, 22);
	assign maj     = (a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q);
	assign t1      = hh_q + big1 + ch + RoundK[round_q] + w_q[0];
	assign t2      = big0 + maj;
	assign bit_len = {count_q, 3'b000};

	assign sts.block_full  = cmd.take_byte && (fill_q == 6'd63);
	assign sts.rounds_done = (round_q == 6'd63);
	assign sts.pad_two     = (fill_q >= 6'd56);

	always_comb begin
		for (int i = 0; i < 8; i++) hash_word[i] = h_q[i];
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			count_q <= '0;
			round_q <= '0;
		end else begin
			if (cmd.take_byte) begin
				fill_q  <= fill_q + 6'd1;
				count_q <= count_q + CountW'(1);
			end
			if (cmd.start_rounds) round_q <= '0;
			else if (cmd.round_step) round_q <= round_q + 6'd1;
			if (cmd.reload) begin
				fill_q  <= '0;
				count_q <= '0;
			end
		end
	end

	// chained hash
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
		end else if (cmd.reload) begin
			for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
		end else if (cmd.fold) begin
			h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q; h_q[3] <= h_q[3] + d_q;
			h_q[4] <= h_q[4] + e_q; h_q[5] <= h_q[5] + f_q;
			h_q[6] <= h_q[6] + g_q; h_q[7] <= h_q[7] + hh_q;
		end
	end

	// working variables, schedule and byte buffer
	always_ff @(posedge clk) begin
		if (cmd.take_byte) begin
			case (fill_q[1:0])
				2'd0:    w_q[fill_q[5:2]][31:24] <= byte_in;
				2'd1:    w_q[fill_q[5:2]][23:16] <= byte_in;
				2'd2:    w_q[fill_q[5:2]][15:8]  <= byte_in;
				default: w_q[fill_q[5:2]][7:0]   <= byte_in;
			endcase
		end else if (cmd.pad_first || cmd.pad_len) begin
			// mark after the last byte, clear the rest, length in the last two words;
			// a block after the one with the mark is all zero but the length
			for (int i = 0; i < 16; i++) begin
				for (int j = 0; j < 4; j++) begin
					if (cmd.pad_len && i >= 14)
						w_q[i][31-8*j -: 8] <= bit_len[32*(15-i)+31-8*j -: 8];
					else if (cmd.pad_first && 6'(i * 4 + j) == fill_q)
						w_q[i][31-8*j -: 8] <= PadMark;
					else if (cmd.pad_first && 6'(i * 4 + j) > fill_q)
						w_q[i][31-8*j -: 8] <= 8'h00;
					else if (cmd.pad_len && fill_q >= 6'd56)
						w_q[i][31-8*j -: 8] <= 8'h00;
				end
			end
		end else if (cmd.round_step) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= w_new;
		end
		if (cmd.start_rounds) begin
			a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3];
			e_q <= h_q[4]; f_q <= h_q[5]; g_q <= h_q[6]; hh_q <= h_q[7];
		end else if (cmd.round_step) begin
			hh_q <= g_q; g_q <= f_q; f_q <= e_q; e_q <= d_q + t1;
			d_q <= c_q; c_q <= b_q; b_q <= a_q; a_q <= t1 + t2;
		end
	end

endmodule

// ===== sv/sha256_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 controller
// Sequences byte intake, block compression, padding blocks and digest beats.
// ----------------------------------------------------------------------------
module sha256_ctrl import sha256_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_fire,
	input  in_beat_t  in_beat,
	input  dp_sts_t   sts,
	input  logic      out_fire,
	output dp_cmd_t   cmd,
	output logic      in_ready,
	output logic      out_valid,
	output logic [2:0] emit_idx,
	output state_t    state
);

	state_t     state_q, state_d;
	logic       eom_q;     // message ends once current block is done
	pad_t       pad_q;     // padding block being compressed
	logic [2:0] idx_q;

	assign state    = state_q;
	assign emit_idx = idx_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (in_beat.has_byte && sts.block_full) state_d = ST_ROUND;
					else if (in_beat.end_of_message) state_d = ST_PAD;
				end
			end
			ST_ROUND: if (sts.rounds_done) state_d = ST_FOLD;
			ST_FOLD: begin
				if (pad_q == PAD_LEN) state_d = ST_EMIT;
				else if (eom_q) state_d = ST_PAD;
				else state_d = ST_IDLE;
			end
			ST_PAD:  state_d = ST_ROUND;
			ST_EMIT: if (out_fire && idx_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd          = '0;
		in_ready     = 1'b0;
		out_valid    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready       = 1'b1;
				cmd.take_byte  = in_fire && in_beat.has_byte;
				cmd.start_rounds = in_fire && in_beat.has_byte && sts.block_full;
			end
			ST_ROUND: cmd.round_step = 1'b1;
			ST_FOLD:  cmd.fold = 1'b1;
			ST_PAD: begin
				cmd.start_rounds = 1'b1;
				if (pad_q == PAD_NONE) cmd.pad_first = 1'b1;
				if (pad_q == PAD_FIRST || !sts.pad_two) cmd.pad_len = 1'b1;
			end
			ST_EMIT: begin
				out_valid  = 1'b1;
				cmd.reload = out_fire && idx_q == 3'd7;
			end
			default: ;
		endcase
	end

	// pad_first and pad_len may both fire; datapath applies mark and length in one write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			eom_q   <= 1'b0;
			pad_q   <= PAD_NONE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && in_fire) eom_q <= in_beat.end_of_message;
			if (state_q == ST_PAD) begin
				if (pad_q == PAD_NONE && sts.pad_two) pad_q <= PAD_FIRST;
				else pad_q <= PAD_LEN;
			end
			if (state_q == ST_EMIT && out_fire) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7) begin
					pad_q <= PAD_NONE;
					eom_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== sv/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher
// Byte-wise SHA-256 with padding and eight-beat digest output.
// ----------------------------------------------------------------------------
// A byte beat is taken while the controller is idle; the 64th byte of a block
// loads the working variables as it is taken and starts a compression (64
// rounds and a fold) during which input is stalled. End of message adds one or
// two padding blocks, each a load, 64 rounds and a fold (two when fewer than
// nine bytes remain free in the last block), then eight digest beats, word 0
// first. The single round unit sets the rate.
module sha256_stream_hasher import sha256_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_beat_t  in_data,
	input  logic      in_valid,
	output logic      in_stall,
	output out_beat_t out_data,
	output logic      out_valid,
	input  logic      out_stall
);

	dp_cmd_t     cmd;
	dp_sts_t     sts;
	logic [31:0] hash_word [8];
	logic        in_ready, in_fire, out_fire;
	logic [2:0]  emit_idx;
	state_t      state;

	assign in_stall = !in_ready;
	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && !out_stall;

	sha256_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .in_beat(in_data), .sts, .out_fire,
		.cmd, .in_ready, .out_valid, .emit_idx, .state
	);

	sha256_datapath u_dp (
		.clk, .arst_n, .cmd, .byte_in(in_data.message_byte), .sts, .hash_word
	);

	// digest beat
	assign out_data.digest_word = hash_word[emit_idx];
	assign out_data.word_index  = emit_idx;
	assign out_data.last_word   = (emit_idx == 3'd7);

	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("input taken during digest output");
	a_emit_from_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> emit_idx == 3'd0) else $error("digest not from word 0");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire && out_data.last_word |=> state == ST_IDLE)
		else $error("no return to idle after last word");

endmodule
